// ===== hw/rtl/fhh_pkg.sv =====
// package for the half-band hilbert transformer: sizes, codes, fsm states
// and the control struct between the top level and the multiply-accumulate unit
// no dependencies
package fhh_pkg;

    localparam int HALF_LEN  = 8;
    localparam int TAPS      = 16;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 15;
    localparam int IDX_W     = $clog2(TAPS);
    localparam int LINE_ADDR_W = IDX_W + 1;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + IDX_W;

    // tap position counted from the oldest entry, clamped to the newest
    localparam logic [IDX_W-1:0] TAP_POS =
        IDX_W'((HALF_LEN - 1 < TAPS) ? (HALF_LEN - 1) : (TAPS - 1));

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;

    localparam logic [1:0] OP_PROCESS = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] MODE_R2C    = 2'd0;
    localparam logic [1:0] MODE_DECIM  = 2'd1;
    localparam logic [1:0] MODE_INTERP = 2'd2;

    localparam logic LINE_UPPER = 1'b0;
    localparam logic LINE_LOWER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_PUSH2,
        S_TAP,
        S_MAC,
        S_DRAIN,
        S_OUT
    } fhh_state_t;

    typedef struct packed {
        logic acc_clear;
        logic mult_en;
    } mac_ctrl_t;

endpackage

// ===== hw/rtl/fhh_mac.sv =====
// shared multiply-accumulate unit with round half up and saturation to q1.15
// depends on fhh_pkg
module fhh_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fhh_pkg::mac_ctrl_t                ctrl,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0] line_data,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0] coef_data,
    output logic                              busy,
    output logic signed [fhh_pkg::SAMPLE_W-1:0] result
);
    import fhh_pkg::*;

    localparam int QW = ACC_W - FRAC_BITS;
    localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [QW-1:0]     q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.mult_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mult_en)
        begin
            prod_reg <= line_data * coef_data;
        end
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor after adding half an lsb
    always_comb
    begin
        rnd = acc_reg + ROUND_HALF;
        q   = QW'(rnd >>> FRAC_BITS);
        if (q > Q_MAX)
        begin
            result = SAMPLE_W'(Q_MAX);
        end
        else if (q < Q_MIN)
        begin
            result = SAMPLE_W'(Q_MIN);
        end
        else
        begin
            result = q[SAMPLE_W-1:0];
        end
    end

    assign busy = prod_v_reg;

endmodule

// ===== hw/rtl/fir_hilbert_halfband_core.sv =====
// top level of the two-branch polyphase half-band hilbert transformer
// depends on fhh_pkg and fhh_mac
//
// usage
//   input channel (in_valid / in_stall) carries one transaction per operation:
//   process samples, load a quadrature coefficient, or clear the delay lines
//   and phase. output channel (out_valid / out_stall) carries one i/q result
//   per process transaction; loads, clears, unused codes and the unused mode
//   give none. the user is to set mode through the apb port only while the
//   block is idle; the block itself does not enforce this.
// process sequence
//   load, clear and ignored transactions leave the block idle. a process
//   transaction makes one or two writes into the delay-line memory, one tap
//   read, then the single multiply-accumulate walks all TAPS coefficients at
//   one memory read per cycle, followed by a drain (memory read, product and
//   accumulator registers) and the output load. the next transaction is
//   accepted in the cycle after the output load; none is accepted before.
// reset
//   delay lines read as zero (per-entry valid bits), phase and mode are zero,
//   coefficients are undefined until loaded.
// stall
//   the finished result sits in the output register; the next transaction is
//   accepted meanwhile, and a new result waits in the output state until the
//   register is free.
module fir_hilbert_halfband_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           operation,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  sample_a,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  sample_b,
    input  logic [3:0]                           coef_index,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  coef_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fhh_pkg::SAMPLE_W-1:0]  out_a,
    output logic signed [fhh_pkg::SAMPLE_W-1:0]  out_b,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fhh_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [fhh_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [fhh_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import fhh_pkg::*;

    localparam int LINE_DEPTH = 1 << LINE_ADDR_W;

    // pointer plus offset, modulo the line length
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] p,
                                                  input logic [IDX_W-1:0] k);
        logic [IDX_W:0] s;
        s = {1'b0, p} + {1'b0, k};
        if (s >= (IDX_W + 1)'(TAPS))
        begin
            s = s - (IDX_W + 1)'(TAPS);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(TAPS - 1)) ? '0 : p + 1'b1;
    endfunction

    fhh_state_t state_reg, state_next;

    logic [1:0]                 mode_reg;
    logic                       phase_reg;
    logic signed [SAMPLE_W-1:0] a_reg, b_reg;
    logic                       push_sel_reg, two_push_reg, tap_sel_reg, dot_sel_reg;
    logic [IDX_W-1:0]           ptr_up_reg, ptr_lo_reg;
    logic [IDX_W-1:0]           cnt_reg;

    // delay-line memory: both lines, addressed {line, slot}, circular per line
    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_DEPTH-1:0]      line_vld_reg;
    logic signed [SAMPLE_W-1:0] coef_mem [TAPS];

    logic signed [SAMPLE_W-1:0] line_q_reg, coef_q_reg, tap_reg;
    logic                       line_ok_reg;
    logic                       rd_tap_v_reg, rd_mac_v_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_a_reg, out_b_reg;

    // combinational controls
    logic                       accept;
    logic                       start;
    logic                       wr_en;
    logic                       wr_sel;
    logic [LINE_ADDR_W-1:0]     wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic [LINE_ADDR_W-1:0]     rd_addr;
    logic                       out_load;
    logic                       coef_we;
    logic                       mac_busy;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_W-1:0] line_eff;
    logic signed [SAMPLE_W-1:0] mac_result;
    logic                       cfg_write;
    logic [REG_IDX_W-1:0]       reg_idx;

    function automatic logic [IDX_W-1:0] ptr_of(input logic sel,
                                                input logic [IDX_W-1:0] up,
                                                input logic [IDX_W-1:0] lo);
        return (sel == LINE_LOWER) ? lo : up;
    endfunction

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_MODE)
        begin
            prdata = APB_DATA_W'(mode_reg);
        end
    end

    // ---------------- fsm ----------------
    assign accept = in_valid && !in_stall;
    assign start  = accept && (operation == OP_PROCESS) &&
                    (mode_reg inside {MODE_R2C, MODE_DECIM, MODE_INTERP});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:  state_next = two_push_reg ? S_PUSH2 : S_TAP;
            S_PUSH2: state_next = S_TAP;
            S_TAP:   state_next = S_MAC;
            S_MAC:
            begin
                if (cnt_reg == IDX_W'(TAPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_mac_v_reg && !mac_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        wr_en    = 1'b0;
        wr_sel   = push_sel_reg;
        wr_data  = a_reg;
        rd_addr  = {dot_sel_reg,
                    wrap_add(ptr_of(dot_sel_reg, ptr_up_reg, ptr_lo_reg), cnt_reg)};
        mac_ctrl.acc_clear = 1'b0;
        mac_ctrl.mult_en   = rd_mac_v_reg;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_PUSH:  wr_en = 1'b1;
            S_PUSH2:
            begin
                // second push of a decimate or interpolate transaction
                wr_en   = 1'b1;
                wr_sel  = LINE_UPPER;
                wr_data = b_reg;
            end
            S_TAP:
            begin
                rd_addr = {tap_sel_reg,
                           wrap_add(ptr_of(tap_sel_reg, ptr_up_reg, ptr_lo_reg), TAP_POS)};
                mac_ctrl.acc_clear = 1'b1;
            end
            S_OUT:   out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
        wr_addr = {wr_sel, ptr_of(wr_sel, ptr_up_reg, ptr_lo_reg)};
    end

    assign coef_we = accept && (operation == OP_LOAD) && (32'(coef_index) < 32'(TAPS));

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_R2C;
            phase_reg     <= 1'b0;
            ptr_up_reg    <= '0;
            ptr_lo_reg    <= '0;
            cnt_reg       <= '0;
            line_vld_reg  <= '0;
            rd_tap_v_reg  <= 1'b0;
            rd_mac_v_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            push_sel_reg  <= LINE_UPPER;
            two_push_reg  <= 1'b0;
            tap_sel_reg   <= LINE_UPPER;
            dot_sel_reg   <= LINE_LOWER;
        end
        else
        begin
            state_reg    <= state_next;
            rd_tap_v_reg <= (state_reg == S_TAP);
            rd_mac_v_reg <= (state_reg == S_MAC);

            if (cfg_write && (reg_idx == REG_MODE))
            begin
                mode_reg <= pwdata[1:0];
            end

            if (accept && (operation == OP_CLEAR))
            begin
                line_vld_reg <= '0;
                phase_reg    <= 1'b0;
                ptr_up_reg   <= '0;
                ptr_lo_reg   <= '0;
            end

            if (start)
            begin
                if (mode_reg == MODE_R2C)
                begin
                    // phase 0 feeds the upper line, phase 1 the lower one
                    push_sel_reg <= phase_reg ? LINE_LOWER : LINE_UPPER;
                    tap_sel_reg  <= phase_reg ? LINE_LOWER : LINE_UPPER;
                    dot_sel_reg  <= phase_reg ? LINE_UPPER : LINE_LOWER;
                    two_push_reg <= 1'b0;
                    phase_reg    <= !phase_reg;
                end
                else
                begin
                    push_sel_reg <= LINE_LOWER;
                    tap_sel_reg  <= LINE_UPPER;
                    dot_sel_reg  <= LINE_LOWER;
                    two_push_reg <= 1'b1;
                end
            end

            if (wr_en)
            begin
                line_vld_reg[wr_addr] <= 1'b1;
                if (wr_sel == LINE_LOWER)
                begin
                    ptr_lo_reg <= wrap_inc(ptr_lo_reg);
                end
                else
                begin
                    ptr_up_reg <= wrap_inc(ptr_up_reg);
                end
            end

            if (state_reg == S_TAP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_MAC)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers and memories ----------------
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= sample_a;
            b_reg <= sample_b;
        end
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        line_q_reg  <= line_mem[rd_addr];
        line_ok_reg <= line_vld_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[IDX_W'(coef_index)] <= coef_value;
        end
        coef_q_reg <= coef_mem[cnt_reg];
    end

    // entries not written since reset or clear read as zero
    assign line_eff = line_ok_reg ? line_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rd_tap_v_reg)
        begin
            tap_reg <= line_eff;
        end
        if (out_load)
        begin
            out_a_reg <= tap_reg;
            out_b_reg <= mac_result;
        end
    end

    fhh_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .line_data (line_eff),
        .coef_data (coef_q_reg),
        .busy      (mac_busy),
        .result    (mac_result)
    );

    assign out_valid = out_valid_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;

endmodule

// ===== tb/sv/fhh_result_checker.sv =====
// result checker for the half-band hilbert transformer: follows the mode register,
// predicts one i/q pair per accepted process transaction in a working mode and
// compares the outputs; depends on fhh_pkg
module fhh_result_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [1:0]                           operation,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  sample_a,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  sample_b,
    input  logic [3:0]                           coef_index,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  coef_value,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  out_a,
    input  logic signed [fhh_pkg::SAMPLE_W-1:0]  out_b,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [fhh_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [fhh_pkg::APB_DATA_W-1:0]       pwdata,
    output int                                   fail_count,
    output int                                   results_owed
);

    import fhh_pkg::*;

    // in-phase tap, counted from the oldest entry
    localparam int TAP_IDX = (HALF_LEN - 1 < TAPS) ? HALF_LEN - 1 : TAPS - 1;

    typedef logic signed [SAMPLE_W-1:0] word_t;
    typedef struct packed {
        word_t in_phase;
        word_t quad;
    } iq_pair_t;

    word_t      line_mem [2][TAPS];
    word_t      coef_mem [TAPS];
    logic       phase_q;
    logic [1:0] mode_q;
    iq_pair_t   iq_expected_q [$];

    function automatic void clear_lines();
        for (int i = 0; i < TAPS; i++)
        begin
            line_mem[LINE_UPPER][i] = '0;
            line_mem[LINE_LOWER][i] = '0;
        end
    endfunction

    function automatic void push_sample(input logic sel, input word_t x);
        for (int i = 0; i < TAPS - 1; i++)
            line_mem[sel][i] = line_mem[sel][i + 1];
        line_mem[sel][TAPS - 1] = x;
    endfunction

    // exact sum of q2.30 products, round half up, then saturate to q1.15
    function automatic word_t quad_dot(input logic sel);
        longint acc;
        acc = 64'sd16384;
        for (int i = 0; i < TAPS; i++)
            acc += longint'(coef_mem[i]) * longint'(line_mem[sel][i]);
        acc = acc >>> FRAC_BITS;
        if (acc > 64'sd32767)
            return 16'sh7fff;
        if (acc < -64'sd32768)
            return 16'sh8000;
        return word_t'(acc);
    endfunction

    function automatic bit predict_iq(input logic [1:0] op, input word_t a, input word_t b,
                                      input logic [3:0] idx, input word_t cv,
                                      output iq_pair_t res);
        res = '0;
        if (op == OP_LOAD)
        begin
            coef_mem[idx] = cv;
            return 1'b0;
        end
        if (op == OP_CLEAR)
        begin
            clear_lines();
            phase_q = 1'b0;
            return 1'b0;
        end
        if (op != OP_PROCESS)
            return 1'b0;
        case (mode_q)
            MODE_R2C:
            begin
                if (phase_q == 1'b0)
                begin
                    push_sample(LINE_UPPER, a);
                    res.in_phase = line_mem[LINE_UPPER][TAP_IDX];
                    res.quad     = quad_dot(LINE_LOWER);
                end
                else
                begin
                    push_sample(LINE_LOWER, a);
                    res.in_phase = line_mem[LINE_LOWER][TAP_IDX];
                    res.quad     = quad_dot(LINE_UPPER);
                end
                phase_q = ~phase_q;
            end
            MODE_DECIM:
            begin
                push_sample(LINE_LOWER, a);
                res.quad = quad_dot(LINE_LOWER);
                push_sample(LINE_UPPER, b);
                res.in_phase = line_mem[LINE_UPPER][TAP_IDX];
            end
            MODE_INTERP:
            begin
                push_sample(LINE_UPPER, b);
                res.in_phase = line_mem[LINE_UPPER][TAP_IDX];
                push_sample(LINE_LOWER, a);
                res.quad = quad_dot(LINE_LOWER);
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        iq_pair_t want;
        iq_pair_t res;
        if (!rst_n)
        begin
            clear_lines();
            for (int i = 0; i < TAPS; i++)
                coef_mem[i] = '0;
            phase_q = 1'b0;
            mode_q  = MODE_R2C;
            iq_expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_MODE)
                mode_q = pwdata[1:0];
            if (out_valid && !out_stall)
            begin
                if (iq_expected_q.size() == 0)
                begin
                    $error("unexpected result: out_a %0d, out_b %0d", out_a, out_b);
                    fail_count++;
                end
                else
                begin
                    want = iq_expected_q.pop_front();
                    if (out_a !== want.in_phase)
                    begin
                        $error("out_a mismatch: expected %0d, actual %0d", want.in_phase, out_a);
                        fail_count++;
                    end
                    if (out_b !== want.quad)
                    begin
                        $error("out_b mismatch: expected %0d, actual %0d", want.quad, out_b);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (predict_iq(operation, sample_a, sample_b, coef_index, coef_value, res))
                    iq_expected_q.push_back(res);
            end
        end
        results_owed = iq_expected_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the half-band hilbert transformer testbench: clock, reset, stimulus,
// mode writes over apb and the verdict
// depends on fhh_pkg, fir_hilbert_halfband_core and fhh_result_checker
module testbench;

    import fhh_pkg::*;

    localparam int PERIOD       = 12;
    localparam int RESET_CYCLES = 8;
    // room for a process transaction still in flight, plus the output register hand-off
    localparam int DRAIN_CYCLES = 2 * (TAPS + 8);
    localparam int PHASE_ITEMS  = 55;
    // overall time limit for the run
    localparam int RUN_LIMIT    = 200000 * PERIOD;

    // codes the block decodes but ignores
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // 0.25 in q1.15
    localparam logic [15:0] COEF_QUARTER = 16'h2000;

    // idle profiles: sender gap percent and receiver stall percent per cycle
    localparam int IDLE_TBL  [3] = '{22, 85, 0};
    localparam int STALL_TBL [3] = '{85, 22, 0};

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   operation;
    logic signed [SAMPLE_W-1:0]   sample_a;
    logic signed [SAMPLE_W-1:0]   sample_b;
    logic [3:0]                   coef_index;
    logic signed [SAMPLE_W-1:0]   coef_value;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   out_a;
    logic signed [SAMPLE_W-1:0]   out_b;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [APB_DATA_W-1:0]        pwdata;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;

    int fail_count;
    int results_owed;
    int idle_pct;
    int stall_pct = 0;

    always #(PERIOD / 2) clk = ~clk;

    fir_hilbert_halfband_core i_dut (.*);

    // watches both channels and the apb port, predicts and compares
    fhh_result_checker i_checker (.*);

    // receiver side: random stall decided once per cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // full-range random half the time, the field extremes and the values
    // around zero the other half
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input transaction; called and returns at a falling edge, valid stays
    // high so back-to-back transactions need no dip
    task automatic send_txn(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b,
                            input logic [3:0] idx, input logic [15:0] cv);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        sample_a   <= a;
        sample_b   <= b;
        coef_index <= idx;
        coef_value <= cv;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // mostly process transactions, with loads, clears and unused codes mixed in
    task automatic random_txn();
        logic [1:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 78)
            op = OP_PROCESS;
        else if (pick < 90)
            op = OP_LOAD;
        else if (pick < 96)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        send_txn(op, pick_word(), pick_word(), 4'($urandom_range(15)), pick_word());
    endtask

    // drop valid, wait for every owed result, then let a no-result
    // transaction still in flight finish
    task automatic settle();
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // apb write of the mode register: setup cycle, then access cycle
    task automatic set_mode(input logic [1:0] m);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= 32'(m);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0] cv;
        in_valid   = 1'b0;
        operation  = OP_PROCESS;
        sample_a   = '0;
        sample_b   = '0;
        coef_index = '0;
        coef_value = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_pct   = IDLE_TBL[0];
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n     <= 1'b1;
        stall_pct <= STALL_TBL[0];
        @(negedge clk);

        // directed: fill the whole coefficient store first so no process
        // transaction ever reads an unloaded coefficient
        set_mode(MODE_R2C);
        for (int i = 0; i < TAPS; i++)
        begin
            if (i == 0)
                cv = 16'h8000;
            else if (i == TAPS - 1)
                cv = 16'h7fff;
            else if (i == 1)
                cv = COEF_QUARTER;
            else
                cv = 16'($urandom);
            send_txn(OP_LOAD, 16'($urandom), 16'($urandom), 4'(i), cv);
        end

        // real to complex: both phases with extreme samples, an unused code,
        // then a clear that resets phase and lines but keeps coefficients
        send_txn(OP_PROCESS, 16'h7fff, 16'h8000, 4'hf, 16'h0000);
        send_txn(OP_PROCESS, 16'h8000, 16'h7fff, 4'h0, 16'hffff);
        send_txn(OP_PROCESS, 16'h7fff, 16'h0000, 4'h5, 16'h1234);
        send_txn(OP_UNUSED, 16'h7fff, 16'h7fff, 4'hf, 16'h7fff);
        send_txn(OP_CLEAR, 16'h8000, 16'h8000, 4'h0, 16'h8000);
        send_txn(OP_PROCESS, 16'hffff, 16'h0001, 4'ha, 16'h5555);

        // decimate and interpolate, extremes on both sample fields
        set_mode(MODE_DECIM);
        send_txn(OP_PROCESS, 16'h8000, 16'h7fff, 4'h3, 16'h0000);
        send_txn(OP_PROCESS, 16'h7fff, 16'h8000, 4'hc, 16'hffff);
        set_mode(MODE_INTERP);
        send_txn(OP_PROCESS, 16'h8000, 16'h7fff, 4'h3, 16'h0000);
        send_txn(OP_PROCESS, 16'h7fff, 16'h8000, 4'hc, 16'hffff);

        // unused mode: process gives nothing, a load still lands
        set_mode(MODE_UNUSED);
        send_txn(OP_PROCESS, 16'h7fff, 16'h7fff, 4'h0, 16'h0000);
        send_txn(OP_LOAD, 16'h0000, 16'h0000, 4'h7, COEF_QUARTER);

        // random: each idle profile runs through all three working modes
        for (int p = 0; p < 3; p++)
        begin
            idle_pct  = IDLE_TBL[p];
            stall_pct <= STALL_TBL[p];
            for (int s = 0; s < 3; s++)
            begin
                set_mode(2'((p + s) % 3));
                repeat (PHASE_ITEMS) random_txn();
            end
        end
        set_mode(MODE_UNUSED);
        repeat (10) random_txn();

        // wait out every owed result and anything still in flight
        settle();
        if (fail_count == 0 && results_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
